### rtl/extended_gcd_bezout_core_macros.svh
// Assertion macros used by the checker file.
`ifndef EXTENDED_GCD_BEZOUT_CORE_MACROS_SVH
`define EXTENDED_GCD_BEZOUT_CORE_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define EGCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds across reset.
`define EGCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/egcd_pkg.sv
package egcd_pkg;

  // Operand width and derived widths
  localparam int WIDTH = 32;
  localparam int CW    = WIDTH + 1;
  localparam int KW    = $clog2(WIDTH);

  typedef logic [WIDTH-1:0]     word_t;
  typedef logic signed [CW-1:0] coeff_t;
  typedef logic [KW-1:0]        shift_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic align_init;
    logic align_step;
    logic div_step;
    logic update;
    logic out_load;
  } egcd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cur_zero;
    logic can_shift;
    logic k_zero;
  } egcd_sts_t;

endpackage

### rtl/egcd_dpath.sv
module egcd_dpath import egcd_pkg::*; (
  input  logic      clk,
  input  word_t     in_operand_a,
  input  word_t     in_operand_b,
  input  egcd_cmd_t cmd,
  output egcd_sts_t sts,
  output word_t     out_divisor,
  output coeff_t    out_coeff_x,
  output coeff_t    out_coeff_y
);

  // Remainder pair and coefficient pairs
  word_t  rp_r, rc_r;
  coeff_t xp_r, xc_r, yp_r, yc_r;
  // Divider: aligned divisor, partial remainder, shift count
  word_t  d_r, rem_r;
  shift_t k_r;
  // Quotient times current coefficient, built MSB first
  coeff_t accx_r, accy_r;
  // Output register
  word_t  out_div_r;
  coeff_t out_x_r, out_y_r;

  word_t  d_dbl;
  word_t  rem_sub;
  logic   ge;
  coeff_t accx_nxt, accy_nxt;

  // Divisor alignment and restoring subtract
  always_comb begin
    d_dbl    = {d_r[WIDTH-2:0], 1'b0};
    ge       = (rem_r >= d_r);
    rem_sub  = rem_r - d_r;
    accx_nxt = {accx_r[CW-2:0], 1'b0} + (ge ? xc_r : '0);
    accy_nxt = {accy_r[CW-2:0], 1'b0} + (ge ? yc_r : '0);
  end

  assign sts.cur_zero  = (rc_r == '0);
  assign sts.can_shift = !d_r[WIDTH-1] && (d_dbl <= rp_r);
  assign sts.k_zero    = (k_r == '0);

  always_ff @(posedge clk) begin
    // New operands, coefficients start at identity
    if (cmd.load) begin
      rp_r <= in_operand_a;
      rc_r <= in_operand_b;
      xp_r <= coeff_t'(1);
      xc_r <= '0;
      yp_r <= '0;
      yc_r <= coeff_t'(1);
    end
    // Start one quotient step
    if (cmd.align_init) begin
      d_r    <= rc_r;
      k_r    <= '0;
      rem_r  <= rp_r;
      accx_r <= '0;
      accy_r <= '0;
    end
    // Shift divisor up under the dividend
    if (cmd.align_step) begin
      d_r <= d_dbl;
      k_r <= k_r + shift_t'(1);
    end
    // One quotient bit per beat
    if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_sub;
      end
      accx_r <= accx_nxt;
      accy_r <= accy_nxt;
      d_r    <= {1'b0, d_r[WIDTH-1:1]};
      k_r    <= k_r - shift_t'(1);
    end
    // Rotate pairs
    if (cmd.update) begin
      rp_r <= rc_r;
      rc_r <= rem_r;
      xp_r <= xc_r;
      xc_r <= xp_r - accx_r;
      yp_r <= yc_r;
      yc_r <= yp_r - accy_r;
    end
    if (cmd.out_load) begin
      out_div_r <= rp_r;
      out_x_r   <= xp_r;
      out_y_r   <= yp_r;
    end
  end

  assign out_divisor = out_div_r;
  assign out_coeff_x = out_x_r;
  assign out_coeff_y = out_y_r;

endmodule

### rtl/egcd_ctrl.sv
module egcd_ctrl import egcd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  egcd_sts_t sts,
  output egcd_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.cur_zero) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.align_init = 1'b1;
          state_nxt      = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (sts.can_shift) begin
          cmd.align_step = 1'b1;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.k_zero) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/extended_gcd_bezout_core.sv
// One item in flight at a time; the next input beat is taken only after the result is loaded
// into the output register. The divider is shared and produces one quotient bit per cycle;
// each quotient step aligns the divisor first. Reset (rst_n low, synchronous) empties the
// output and returns to idle.
module extended_gcd_bezout_core import egcd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  word_t  in_operand_a,
  input  word_t  in_operand_b,
  output logic   out_valid,
  input  logic   out_ready,
  output word_t  out_divisor,
  output coeff_t out_coeff_x,
  output coeff_t out_coeff_y
);

  egcd_cmd_t cmd;
  egcd_sts_t sts;

  // Sequencer
  egcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Remainder, coefficient and divider registers
  egcd_dpath u_dpath (
    .clk          (clk),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .cmd          (cmd),
    .sts          (sts),
    .out_divisor  (out_divisor),
    .out_coeff_x  (out_coeff_x),
    .out_coeff_y  (out_coeff_y)
  );

endmodule

### rtl/egcd_checker.sv
`include "extended_gcd_bezout_core_macros.svh"

module egcd_checker import egcd_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input word_t  out_divisor,
  input coeff_t out_coeff_x,
  input coeff_t out_coeff_y
);

  // Stalled result beat holds
  `EGCD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_divisor) && $stable(out_coeff_x) && $stable(out_coeff_y), "result changed while stalled")

  // Only one item in flight: busy right after an accepted beat
  `EGCD_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "input taken while busy")

  // gcd of zero only comes from two zero operands: (0, 1, 0)
  `EGCD_ASSERT(a_zero_gcd, clk, rst_n, out_valid && (out_divisor == '0) |-> (out_coeff_x == 1) && (out_coeff_y == 0), "bad coefficients for zero gcd")

  // Reset leaves the block idle and the output empty
  `EGCD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind extended_gcd_bezout_core egcd_checker u_egcd_checker (.*);
